// ----- hdl/sapa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sapa_pkg;

   // Stream word as carried on the input channel.
   localparam int FIELD_BITS = 32;
   // Number of low bits of each stream word that take part in the product.
   localparam int WORD_BITS = 32;
   localparam int USE_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
   localparam int POP_W = $clog2(USE_BITS + 1);

   localparam int COUNT_W = 12;
   localparam int TOTAL_W = 20;
   localparam int CFG_DATA_W = 12;
   localparam int CSR_INDEX_W = 1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'd524288;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD_MODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_LIMIT = 1'd1;

   // Number of ones among the bits of a word that take part.
   function automatic logic [POP_W-1:0] popcount(input logic [FIELD_BITS-1:0] w);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < USE_BITS; i++) begin
         n = n + {{(POP_W-1){1'b0}}, w[i]};
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/sapa_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sapa_req_if;
   logic                             valid;
   logic                             ready;
   logic [sapa_pkg::FIELD_BITS-1:0]  act_word;
   logic [sapa_pkg::FIELD_BITS-1:0]  pos_weight_word;
   logic [sapa_pkg::FIELD_BITS-1:0]  neg_weight_word;
   logic                             last_pack;
   logic                             last_bit;

   modport source (
      output valid, act_word, pos_weight_word, neg_weight_word, last_pack, last_bit,
      input  ready
   );
   modport sink (
      input  valid, act_word, pos_weight_word, neg_weight_word, last_pack, last_bit,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/sapa_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sapa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sapa_pkg::TOTAL_W-1:0]  pos_total;
   logic [sapa_pkg::TOTAL_W-1:0]  neg_total;

   modport source (
      output valid, pos_total, neg_total,
      input  ready
   );
   modport sink (
      input  valid, pos_total, neg_total,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/stochastic_and_popcount_accumulator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A transaction is first registered in the input stage; from there it updates the counts
// and totals, and when it closes the last bit step its result is loaded into the
// result register and offered on rsp_bus. Throughput: one transaction per cycle, except
// that a result waiting on an occupied, untaken result register stalls the input.
// Reset (synchronous, active high) clears all counts, totals and valid flags and sets
// saturate mode with a bin limit of one.
module stochastic_and_popcount_accumulator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sapa_req_if.sink                               req_bus,
   sapa_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_we,
   input  wire logic [sapa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sapa_pkg::CFG_DATA_W-1:0]   csr_wdata
);

   // Configuration registers.
   logic                           mode_ff;
   logic [sapa_pkg::COUNT_W-1:0]   limit_ff;

   // Input register stage.
   logic                              s1_vld_ff, s1_vld_in;
   logic [sapa_pkg::FIELD_BITS-1:0]   s1_act_ff, s1_pw_ff, s1_nw_ff;
   logic                              s1_last_pack_ff, s1_last_bit_ff;

   // Accumulation state.
   logic [sapa_pkg::COUNT_W-1:0]   pos_count_ff, pos_count_in;
   logic [sapa_pkg::COUNT_W-1:0]   neg_count_ff, neg_count_in;
   logic [sapa_pkg::TOTAL_W-1:0]   pos_accum_ff, pos_accum_in;
   logic [sapa_pkg::TOTAL_W-1:0]   neg_accum_ff, neg_accum_in;

   // Result register.
   logic                           out_vld_ff, out_vld_in;
   logic [sapa_pkg::TOTAL_W-1:0]   out_pos_ff, out_neg_ff;

   logic                           req_take;
   logic                           s1_emit;
   logic                           s1_adv;
   logic [sapa_pkg::COUNT_W-1:0]   pos_cnt_new, neg_cnt_new;
   logic [sapa_pkg::TOTAL_W-1:0]   pos_acc_new, neg_acc_new;

   // ------------------------------------------------------------------
   // Configuration writes, only while the block is idle (a user rule, unenforced).
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         limit_ff <= sapa_pkg::COUNT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            sapa_pkg::CSR_THRESHOLD_MODE: begin
               mode_ff <= csr_wdata[0];
            end
            sapa_pkg::CSR_BIN_LIMIT: begin
               limit_ff <= csr_wdata[sapa_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control. The staged transaction only waits when it carries a
   // result and the result register is still occupied by one that the
   // consumer has not taken. Transactions that close nothing never wait.
   // ------------------------------------------------------------------
   assign s1_emit       = s1_last_pack_ff & s1_last_bit_ff;
   assign s1_adv        = s1_vld_ff & ~(s1_emit & out_vld_ff & ~rsp_bus.ready);
   assign req_bus.ready = ~s1_vld_ff | s1_adv;
   assign req_take      = req_bus.valid & req_bus.ready;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_take) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_act_ff       <= req_bus.act_word;
         s1_pw_ff        <= req_bus.pos_weight_word;
         s1_nw_ff        <= req_bus.neg_weight_word;
         s1_last_pack_ff <= req_bus.last_pack;
         s1_last_bit_ff  <= req_bus.last_bit;
      end
   end

   // ------------------------------------------------------------------
   // Datapath: AND and popcount, saturating partial count, binning and
   // saturating total, all in the single stage after the input register.
   // ------------------------------------------------------------------
   function automatic logic [sapa_pkg::COUNT_W-1:0] count_add(
      input logic [sapa_pkg::COUNT_W-1:0] c,
      input logic [sapa_pkg::POP_W-1:0]   p
   );
      logic [sapa_pkg::COUNT_W:0] s;
      s = {1'b0, c} + (sapa_pkg::COUNT_W + 1)'(p);
      return s[sapa_pkg::COUNT_W] ? sapa_pkg::COUNT_MAX : s[sapa_pkg::COUNT_W-1:0];
   endfunction

   // Saturate mode clamps the count to the limit; threshold mode gives one
   // when the count reaches the limit and zero otherwise.
   function automatic logic [sapa_pkg::COUNT_W-1:0] bin_value(
      input logic [sapa_pkg::COUNT_W-1:0] c,
      input logic                         thr,
      input logic [sapa_pkg::COUNT_W-1:0] lim
   );
      logic [sapa_pkg::COUNT_W-1:0] r;
      if (thr) begin
         r = (c >= lim) ? sapa_pkg::COUNT_W'(1) : '0;
      end else begin
         r = (c < lim) ? c : lim;
      end
      return r;
   endfunction

   function automatic logic [sapa_pkg::TOTAL_W-1:0] total_add(
      input logic [sapa_pkg::TOTAL_W-1:0] t,
      input logic [sapa_pkg::COUNT_W-1:0] b
   );
      logic [sapa_pkg::TOTAL_W:0] s;
      s = {1'b0, t} + (sapa_pkg::TOTAL_W + 1)'(b);
      return (s > {1'b0, sapa_pkg::TOTAL_MAX}) ? sapa_pkg::TOTAL_MAX
                                              : s[sapa_pkg::TOTAL_W-1:0];
   endfunction

   assign pos_cnt_new = count_add(pos_count_ff, sapa_pkg::popcount(s1_act_ff & s1_pw_ff));
   assign neg_cnt_new = count_add(neg_count_ff, sapa_pkg::popcount(s1_act_ff & s1_nw_ff));
   assign pos_acc_new = total_add(pos_accum_ff, bin_value(pos_cnt_new, mode_ff, limit_ff));
   assign neg_acc_new = total_add(neg_accum_ff, bin_value(neg_cnt_new, mode_ff, limit_ff));

   always_comb begin
      pos_count_in = pos_count_ff;
      neg_count_in = neg_count_ff;
      pos_accum_in = pos_accum_ff;
      neg_accum_in = neg_accum_ff;
      if (s1_adv) begin
         if (!s1_last_pack_ff) begin
            pos_count_in = pos_cnt_new;
            neg_count_in = neg_cnt_new;
         end else begin
            // End of a bit step: fold the binned counts into the totals,
            // and start over once the last bit step has been emitted.
            pos_count_in = '0;
            neg_count_in = '0;
            if (s1_last_bit_ff) begin
               pos_accum_in = '0;
               neg_accum_in = '0;
            end else begin
               pos_accum_in = pos_acc_new;
               neg_accum_in = neg_acc_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_count_ff <= '0;
         neg_count_ff <= '0;
         pos_accum_ff <= '0;
         neg_accum_ff <= '0;
      end else begin
         pos_count_ff <= pos_count_in;
         neg_count_ff <= neg_count_in;
         pos_accum_ff <= pos_accum_in;
         neg_accum_ff <= neg_accum_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. It holds a finished result while the next transactions
   // that close nothing keep flowing through the input stage.
   // ------------------------------------------------------------------
   always_comb begin
      out_vld_in = out_vld_ff & ~rsp_bus.ready;
      if (s1_adv && s1_emit) begin
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit) begin
         out_pos_ff <= pos_acc_new;
         out_neg_ff <= neg_acc_new;
      end
   end

   assign rsp_bus.valid     = out_vld_ff;
   assign rsp_bus.pos_total = out_pos_ff;
   assign rsp_bus.neg_total = out_neg_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // Input backpressure only arises from a result waiting behind a full
   // result register.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_vld_ff && s1_emit && out_vld_ff && !rsp_bus.ready))
      else $error("input stalled without a blocked result");

   // Closing a bit step clears both partial counts.
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_pack_ff) |=> (pos_count_ff == '0 && neg_count_ff == '0))
      else $error("partial counts not cleared at end of bit step");

   // Running totals never pass their saturation point.
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      (pos_accum_ff <= sapa_pkg::TOTAL_MAX) && (neg_accum_ff <= sapa_pkg::TOTAL_MAX))
      else $error("running total above saturation limit");

   // Emitting a result restarts the totals from zero.
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit) |=> (pos_accum_ff == '0 && neg_accum_ff == '0 && out_vld_ff))
      else $error("totals not cleared or result not loaded on emit");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the stochastic AND/popcount accumulator.
//
// The stimulus process sends stream words, each a transaction on the request
// channel. Every accepted word goes into a predictor that keeps its own partial
// counts, running totals and register copy. A separate process drains the result
// channel, and each result is compared with the oldest predicted pair of totals.
// Registers are only rewritten once the block has gone quiet.
module tb;

   localparam int HOLD_OFF = 200;       // long receiver stall that backs the block up
   localparam int SETTLE = 4;           // edges for an in-flight update to land
   localparam int RANDOM_WORDS = 900;
   localparam int SAT_RUN = 129;        // 129 full words overflow a 12-bit count
   localparam bit MODE_SATURATE = 1'b0;
   localparam bit MODE_THRESHOLD = 1'b1;

   typedef logic [sapa_pkg::COUNT_W-1:0] count_type;
   typedef logic [sapa_pkg::TOTAL_W-1:0] total_type;

   typedef struct packed {
      logic [sapa_pkg::FIELD_BITS-1:0] act;
      logic [sapa_pkg::FIELD_BITS-1:0] pos_w;
      logic [sapa_pkg::FIELD_BITS-1:0] neg_w;
      logic                            last_pack;
      logic                            last_bit;
   } stream_word_type;

   typedef struct packed {
      total_type pos;
      total_type neg;
   } totals_type;

   // Predicts the emitted totals and checks what the block returns.
   class binned_totals_type;
      bit           mode;
      count_type    limit;
      count_type    pos_count;
      count_type    neg_count;
      total_type    pos_total;
      total_type    neg_total;
      totals_type   pending[$];
      int           errors;
      int           results;

      function new();
         mode = MODE_SATURATE;
         limit = count_type'(1);
         pos_count = '0;
         neg_count = '0;
         pos_total = '0;
         neg_total = '0;
      endfunction

      function void set_register(logic [sapa_pkg::CSR_INDEX_W-1:0] index,
                                 logic [sapa_pkg::CFG_DATA_W-1:0] data);
         if (index == sapa_pkg::CSR_THRESHOLD_MODE)
            mode = data[0];
         else if (index == sapa_pkg::CSR_BIN_LIMIT)
            limit = data[sapa_pkg::COUNT_W-1:0];
      endfunction

      function int unsigned ones(logic [sapa_pkg::FIELD_BITS-1:0] w);
         int unsigned n;
         n = 0;
         for (int i = 0; i < sapa_pkg::USE_BITS; i++)
            n += w[i];
         return n;
      endfunction

      function count_type count_plus(count_type c, int unsigned add);
         int unsigned s;
         s = c + add;
         return (s > sapa_pkg::COUNT_MAX) ? sapa_pkg::COUNT_MAX : count_type'(s);
      endfunction

      function int unsigned bin(count_type c);
         if (mode == MODE_THRESHOLD)
            return (c >= limit) ? 1 : 0;
         return (c < limit) ? c : limit;
      endfunction

      function total_type total_plus(total_type t, int unsigned add);
         int unsigned s;
         s = t + add;
         return (s > sapa_pkg::TOTAL_MAX) ? sapa_pkg::TOTAL_MAX : total_type'(s);
      endfunction

      function void note_word(stream_word_type w);
         totals_type done;
         pos_count = count_plus(pos_count, ones(w.act & w.pos_w));
         neg_count = count_plus(neg_count, ones(w.act & w.neg_w));
         if (!w.last_pack)
            return;
         pos_total = total_plus(pos_total, bin(pos_count));
         neg_total = total_plus(neg_total, bin(neg_count));
         pos_count = '0;
         neg_count = '0;
         if (!w.last_bit)
            return;
         done.pos = pos_total;
         done.neg = neg_total;
         pending.push_back(done);
         pos_total = '0;
         neg_total = '0;
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40)
            $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      task check_totals(total_type pos, total_type neg);
         totals_type want;
         results++;
         if (pending.size() == 0) begin
            report($sformatf("result pos=%0d neg=%0d with nothing expected", pos, neg));
            return;
         end
         want = pending.pop_front();
         if (pos !== want.pos)
            report($sformatf("pos_total %0d, expected %0d", pos, want.pos));
         if (neg !== want.neg)
            report($sformatf("neg_total %0d, expected %0d", neg, want.neg));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [sapa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sapa_pkg::CFG_DATA_W-1:0] csr_wdata;

   sapa_req_if req_bus ();
   sapa_rsp_if rsp_bus ();

   stochastic_and_popcount_accumulator_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   binned_totals_type model = new();

   int words_sent;
   int settings_used;
   bit quiet;          // when set, neither side inserts gaps
   int hold_asks;      // bumped by the stimulus to request a long receiver stall
   int hold_served;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Gap lengths: mostly none, some short, a few long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (quiet || r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One lane of stream bits with a density chosen at random, so that both
   // sparse and dense products show up.
   function automatic logic [sapa_pkg::FIELD_BITS-1:0] lane_word();
      case ($urandom_range(4))
         0: return '1;
         1: return '0;
         2: return $urandom & $urandom & $urandom;
         3: return $urandom | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // Offers one stream word and returns at the edge where it was taken. Valid is
   // left high when the next word follows without a gap.
   task automatic send_word(stream_word_type w);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.act_word <= w.act;
      req_bus.pos_weight_word <= w.pos_w;
      req_bus.neg_weight_word <= w.neg_w;
      req_bus.last_pack <= w.last_pack;
      req_bus.last_bit <= w.last_bit;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      model.note_word(w);
      words_sent++;
   endtask

   // A well-formed output element: a number of bit steps, each closed by a
   // last_pack word, the final one also flagged last_bit. Inner words carry a
   // stray last_bit now and then, which the block must ignore. A pack count of
   // zero picks a random count for each bit step.
   task automatic send_sequence(int steps, int packs);
      int n;
      stream_word_type w;
      for (int b = 0; b < steps; b++) begin
         n = packs;
         if (n == 0) begin
            case ($urandom_range(19))
               0: n = $urandom_range(9, 24);
               1, 2, 3: n = $urandom_range(4, 8);
               default: n = $urandom_range(1, 3);
            endcase
         end
         for (int p = 0; p < n; p++) begin
            w.act = lane_word();
            w.pos_w = lane_word();
            w.neg_w = lane_word();
            w.last_pack = (p == n - 1);
            w.last_bit = w.last_pack ? (b == steps - 1) : ($urandom_range(3) == 0);
            send_word(w);
         end
      end
   endtask

   // Stop offering words and wait until every predicted result has been seen,
   // then give the last update time to land.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (model.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes the mode register, then the limit one. The spare upper bits of the mode
   // write carry junk, which only bit zero of that register should see past.
   task automatic write_config(bit mode, count_type limit,
                               logic [sapa_pkg::CFG_DATA_W-2:0] junk);
      csr_we <= 1'b1;
      csr_index <= sapa_pkg::CSR_THRESHOLD_MODE;
      csr_wdata <= {junk, mode};
      @(posedge clock);
      model.set_register(sapa_pkg::CSR_THRESHOLD_MODE, {junk, mode});
      csr_index <= sapa_pkg::CSR_BIN_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      model.set_register(sapa_pkg::CSR_BIN_LIMIT, limit);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Result side: checks every accepted result and chooses ready for the next
   // cycle. A hold request from the stimulus turns into one long stall, counted
   // here, during which the block has to back up and refuse input.
   initial begin : take_results
      int g;
      int stall_left;
      stall_left = 0;
      hold_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            model.check_totals(rsp_bus.pos_total, rsp_bus.neg_total);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            stall_left = HOLD_OFF - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            g = gap_len();
            if (g > 0) begin
               stall_left = g - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog. The slowest legal run, with every gap at its longest, stays under
   // a quarter of this.
   initial begin
      #5_000_000;
      $display("stochastic_and_popcount_accumulator_top regression: fail");
      $finish;
   end

   initial begin : stimulus
      localparam logic [sapa_pkg::FIELD_BITS-1:0] ONES = '1;
      localparam logic [sapa_pkg::FIELD_BITS-1:0] NONE = '0;
      int random_start;
      int phase_start;
      int phase_len;
      int limit_pick;
      bit held;
      count_type limit;
      stream_word_type w;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= sapa_pkg::CSR_THRESHOLD_MODE;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.act_word <= '0;
      req_bus.pos_weight_word <= '0;
      req_bus.neg_weight_word <= '0;
      req_bus.last_pack <= 1'b0;
      req_bus.last_bit <= 1'b0;
      words_sent = 0;
      settings_used = 0;
      quiet = 1'b0;
      hold_asks = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words, first under the reset setting: saturate with a limit
      // of one. An all-zero element, then a full positive product.
      send_word('{NONE, NONE, NONE, 1'b1, 1'b1});
      send_word('{ONES, ONES, NONE, 1'b1, 1'b1});
      // A last_bit without last_pack must not close anything.
      send_word('{ONES, NONE, ONES, 1'b0, 1'b1});
      send_word('{ONES, ONES, ONES, 1'b1, 1'b0});
      send_word('{NONE, NONE, NONE, 1'b1, 1'b1});

      // Threshold exactly reached on the positive side, missed on the negative.
      drain();
      write_config(MODE_THRESHOLD, 12'd64, '0);
      send_word('{ONES, ONES, ONES, 1'b0, 1'b0});
      send_word('{ONES, ONES, NONE, 1'b1, 1'b0});
      send_word('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1});

      // A limit of zero: saturate yields nothing, threshold always fires.
      drain();
      write_config(MODE_SATURATE, 12'd0, '1);
      send_word('{ONES, ONES, ONES, 1'b1, 1'b1});
      drain();
      write_config(MODE_THRESHOLD, 12'd0, '0);
      send_word('{NONE, NONE, NONE, 1'b1, 1'b1});

      // Top of the nominal range, with the lowest and highest lanes alone.
      drain();
      write_config(MODE_SATURATE, 12'd2048, '0);
      send_word('{32'h8000_0001, ONES, 32'h0000_0001, 1'b1, 1'b1});

      // Overflow: 129 full words in one bit step push each partial count past
      // its 12-bit range, and the largest limit lets the saturated count through.
      // No gaps here, to keep the run short.
      drain();
      write_config(MODE_SATURATE, sapa_pkg::COUNT_MAX, '0);
      quiet = 1'b1;
      for (int p = 0; p < SAT_RUN; p++)
         send_word('{ONES, ONES, ONES, p == SAT_RUN - 1, p == SAT_RUN - 1});
      // A saturated count still meets the largest threshold; an empty one does not.
      drain();
      write_config(MODE_THRESHOLD, sapa_pkg::COUNT_MAX, '0);
      for (int p = 0; p < SAT_RUN; p++)
         send_word('{ONES, ONES, NONE, 1'b0, 1'b0});
      send_word('{NONE, NONE, NONE, 1'b1, 1'b1});
      quiet = 1'b0;

      // Random part: phases of random settings, mostly well-formed elements with
      // random content, some loose words with random flags. Each phase ends with
      // the sender paused until every expected result is back.
      random_start = words_sent;
      phase_start = words_sent;
      phase_len = 0;
      held = 1'b0;
      while (words_sent - random_start < RANDOM_WORDS) begin
         if (words_sent - phase_start >= phase_len) begin
            drain();
            limit_pick = $urandom_range(99);
            if (limit_pick < 50)
               limit = count_type'($urandom_range(1, 64));
            else if (limit_pick < 75)
               limit = count_type'($urandom_range(65, 2048));
            else if (limit_pick < 88)
               limit = count_type'($urandom_range(2049, 4095));
            else
               limit = '0;
            write_config(1'($urandom_range(1)), limit,
                         (sapa_pkg::CFG_DATA_W - 1)'($urandom));
            quiet = ($urandom_range(5) == 0);
            phase_start = words_sent;
            phase_len = $urandom_range(80, 160);
         end
         if (!held && words_sent - random_start > RANDOM_WORDS / 3) begin
            // Single-word elements while the receiver stalls: each one makes a
            // result, so the block fills and must hold off the sender.
            held = 1'b1;
            hold_asks++;
            repeat (24) send_sequence(1, 1);
         end else if ($urandom_range(9) == 0) begin
            w.act = $urandom;
            w.pos_w = $urandom;
            w.neg_w = $urandom;
            w.last_pack = 1'($urandom_range(1));
            w.last_bit = 1'($urandom_range(1));
            send_word(w);
         end else begin
            send_sequence(($urandom_range(4) == 0) ? $urandom_range(5, 12)
                                                   : $urandom_range(1, 4), 0);
         end
      end

      drain();
      quiet = 1'b1;
      repeat (20) @(posedge clock);
      if (model.pending.size() != 0)
         model.report($sformatf("%0d results never arrived", model.pending.size()));
      $display("Sent %0d stream words under %0d register settings; checked %0d results.",
               words_sent, settings_used, model.results);
      $display("Covered zero and out-of-range limits, partial count saturation, ",
               "stray last_bit flags and a long result-side stall.");
      if (model.errors == 0) begin
         $display("stochastic_and_popcount_accumulator_top regression: pass");
      end else begin
         $display("stochastic_and_popcount_accumulator_top regression: fail");
      end
      $finish;
   end

endmodule
